/* hw/rtl/qconv_pkg.sv */
// ----------------------------------------------------------------------------
// qconv_pkg: shared types and constants
// Store sizes, field widths, mode and register codes, and the sequencer states
// of the quantized same-padded 1D convolution block.
// ----------------------------------------------------------------------------
package qconv_pkg;

  localparam int ACT_DEPTH    = 2048;
  localparam int WEIGHT_DEPTH = 2048;
  localparam int MAX_OUT_CH   = 32;

  localparam int ACT_AW  = $clog2(ACT_DEPTH);
  localparam int WGT_AW  = $clog2(WEIGHT_DEPTH);
  localparam int BIAS_AW = $clog2(MAX_OUT_CH);

  localparam logic [1:0] MODE_WEIGHT  = 2'd0;
  localparam logic [1:0] MODE_BIAS    = 2'd1;
  localparam logic [1:0] MODE_ACT     = 2'd2;
  localparam logic [1:0] MODE_COMPUTE = 2'd3;

  localparam logic [2:0] REG_IN_LEN      = 3'd0;
  localparam logic [2:0] REG_IN_CHANNELS = 3'd1;
  localparam logic [2:0] REG_N_TAPS      = 3'd2;
  localparam logic [2:0] REG_PAD         = 3'd3;
  localparam logic [2:0] REG_W_SCALE     = 3'd4;
  localparam logic [2:0] REG_B_SCALE     = 3'd5;
  localparam logic [2:0] REG_RELU_ENABLE = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE1,
    S_BASE2,
    S_BASE3,
    S_MAC,
    S_DRAIN1,
    S_DRAIN2,
    S_FIN1,
    S_FIN2,
    S_FIN3,
    S_FIN4,
    S_FIN5
  } state_t;

endpackage

/* hw/rtl/quantized_conv1d_same.sv */
// ----------------------------------------------------------------------------
// quantized_conv1d_same: same-padded 1D convolution, int8 weights and bias
// A compute word runs one multiply-accumulate for each input channel and tap,
// framed by setup, drain and scaling steps (setup and scaling only when the
// sum is empty), all on one shared 25x25 multiplier; no new word is taken
// meanwhile, and a stalled result holds the sequencer in its last step.
// Synchronous reset restores the register defaults and the idle state; the
// stores are not cleared.
// ----------------------------------------------------------------------------
module quantized_conv1d_same (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          mode,
  input  logic [10:0]         address,
  input  logic signed [7:0]   weight_value,
  input  logic signed [17:0]  activation_value,
  input  logic [4:0]          out_channel,
  input  logic [8:0]          position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [17:0]  out_value,
  output logic [4:0]          out_channel_echo,
  output logic [8:0]          position_echo
);

  logic [9:0]         in_len;
  logic [4:0]         in_channels;
  logic [3:0]         n_taps;
  logic [2:0]         pad;
  logic signed [23:0] w_scale;
  logic signed [23:0] b_scale;
  logic               relu_enable;

  qconv_pkg::state_t state, state_next;

  logic               in_accept;
  logic [4:0]         oc;
  logic [8:0]         pos;
  logic [4:0]         ic;
  logic [3:0]         k;
  logic [qconv_pkg::WGT_AW-1:0] widx;
  logic [qconv_pkg::ACT_AW-1:0] xbase;
  logic               p1_v, p2_v;
  logic signed [39:0] acc;
  logic signed [27:0] b16;
  logic signed [63:0] lo_sum;
  logic signed [63:0] sum;

  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod;

  logic               last_tap;
  logic               empty_sum;
  logic signed [10:0] idx;
  logic               idx_ok;
  logic [qconv_pkg::ACT_AW-1:0] xaddr;
  logic signed [7:0]  w_rdata;
  logic signed [17:0] x_rdata;
  logic signed [7:0]  b_rdata;
  logic signed [24:0] ws_round;
  logic signed [20:0] ws16;
  logic signed [40:0] acc_sum;
  logic signed [32:0] b_round;
  logic signed [63:0] r_wide;
  logic signed [17:0] r_sat;
  logic               out_load;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != qconv_pkg::S_IDLE);
  assign last_tap  = (ic == in_channels - 5'd1) && (k == n_taps - 4'd1);
  assign empty_sum = (in_channels == 5'd0) || (n_taps == 4'd0);
  assign idx       = $signed({2'b00, pos}) + $signed({7'b0, k}) - $signed({8'b0, pad});
  assign idx_ok    = !idx[10] && (idx[9:0] < in_len);
  assign xaddr     = xbase + idx[qconv_pkg::ACT_AW-1:0];
  assign ws_round  = 25'(w_scale) + 25'sd8;
  assign ws16      = ws_round[24:4];
  assign acc_sum   = 41'(acc) + (41'($signed(prod[25:0])) <<< 6);
  assign b_round   = 33'(prod[31:0]) + 33'sd8;
  assign r_wide    = (sum + 64'sd2097152) >>> 22;
  assign out_load  = !out_valid || !out_stall;

  always_comb begin
    if (r_wide > 64'sd131071) begin
      r_sat = 18'sd131071;
    end else if (r_wide < -64'sd131072) begin
      r_sat = -18'sd131072;
    end else begin
      r_sat = r_wide[17:0];
    end
    if (relu_enable && r_sat[17]) begin
      r_sat = '0;
    end
  end

  qconv_ram #(.WIDTH(8), .DEPTH(qconv_pkg::WEIGHT_DEPTH)) u_weight (
    .clk(clk),
    .we(in_accept && mode == qconv_pkg::MODE_WEIGHT),
    .waddr(address[qconv_pkg::WGT_AW-1:0]),
    .wdata(weight_value),
    .raddr(widx),
    .rdata(w_rdata)
  );

  qconv_ram #(.WIDTH(8), .DEPTH(qconv_pkg::MAX_OUT_CH)) u_bias (
    .clk(clk),
    .we(in_accept && mode == qconv_pkg::MODE_BIAS &&
        address < 11'(qconv_pkg::MAX_OUT_CH)),
    .waddr(address[qconv_pkg::BIAS_AW-1:0]),
    .wdata(weight_value),
    .raddr(oc[qconv_pkg::BIAS_AW-1:0]),
    .rdata(b_rdata)
  );

  qconv_ram #(.WIDTH(18), .DEPTH(qconv_pkg::ACT_DEPTH)) u_act (
    .clk(clk),
    .we(in_accept && mode == qconv_pkg::MODE_ACT),
    .waddr(address[qconv_pkg::ACT_AW-1:0]),
    .wdata(activation_value),
    .raddr(xaddr),
    .rdata(x_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      qconv_pkg::S_IDLE: begin
        if (in_accept && mode == qconv_pkg::MODE_COMPUTE) begin
          state_next = qconv_pkg::S_BASE1;
        end
      end
      qconv_pkg::S_BASE1: state_next = qconv_pkg::S_BASE2;
      qconv_pkg::S_BASE2: state_next = qconv_pkg::S_BASE3;
      qconv_pkg::S_BASE3: begin
        state_next = empty_sum ? qconv_pkg::S_FIN1 : qconv_pkg::S_MAC;
      end
      qconv_pkg::S_MAC: begin
        if (last_tap) begin
          state_next = qconv_pkg::S_DRAIN1;
        end
      end
      qconv_pkg::S_DRAIN1: state_next = qconv_pkg::S_DRAIN2;
      qconv_pkg::S_DRAIN2: state_next = qconv_pkg::S_FIN1;
      qconv_pkg::S_FIN1:   state_next = qconv_pkg::S_FIN2;
      qconv_pkg::S_FIN2:   state_next = qconv_pkg::S_FIN3;
      qconv_pkg::S_FIN3:   state_next = qconv_pkg::S_FIN4;
      qconv_pkg::S_FIN4:   state_next = qconv_pkg::S_FIN5;
      qconv_pkg::S_FIN5: begin
        if (out_load) begin
          state_next = qconv_pkg::S_IDLE;
        end
      end
      default: state_next = qconv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mul_a = 25'(x_rdata);
    mul_b = 25'(w_rdata);
    unique case (state)
      qconv_pkg::S_BASE1: begin
        mul_a = 25'({1'b0, oc});
        mul_b = 25'({1'b0, in_channels});
      end
      qconv_pkg::S_BASE2: begin
        mul_a = 25'({1'b0, prod[9:0]});
        mul_b = 25'({1'b0, n_taps});
      end
      qconv_pkg::S_FIN1: begin
        mul_a = 25'(b_rdata);
        mul_b = 25'(b_scale);
      end
      qconv_pkg::S_FIN2: begin
        mul_a = 25'({1'b0, acc[18:0]});
        mul_b = 25'(ws16);
      end
      qconv_pkg::S_FIN3: begin
        mul_a = 25'($signed(acc[39:19]));
        mul_b = 25'(ws16);
      end
      default: begin
        mul_a = 25'(x_rdata);
        mul_b = 25'(w_rdata);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= qconv_pkg::S_IDLE;
      in_len      <= 10'd512;
      in_channels <= 5'd1;
      n_taps      <= 4'd7;
      pad         <= 3'd3;
      w_scale     <= '0;
      b_scale     <= '0;
      relu_enable <= 1'b1;
      p1_v        <= 1'b0;
      p2_v        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          qconv_pkg::REG_IN_LEN:      in_len      <= cfg_data[9:0];
          qconv_pkg::REG_IN_CHANNELS: in_channels <= cfg_data[4:0];
          qconv_pkg::REG_N_TAPS:      n_taps      <= cfg_data[3:0];
          qconv_pkg::REG_PAD:         pad         <= cfg_data[2:0];
          qconv_pkg::REG_W_SCALE:     w_scale     <= cfg_data;
          qconv_pkg::REG_B_SCALE:     b_scale     <= cfg_data;
          qconv_pkg::REG_RELU_ENABLE: relu_enable <= cfg_data[0];
          default: ;
        endcase
      end
      p1_v <= (state == qconv_pkg::S_MAC) && idx_ok;
      p2_v <= p1_v;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == qconv_pkg::S_FIN5 && out_load) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_accept) begin
      oc  <= out_channel;
      pos <= position;
    end
    if (p2_v) begin
      if (acc_sum > 41'sd549755813887) begin
        acc <= 40'sh7FFFFFFFFF;
      end else if (acc_sum < -41'sd549755813888) begin
        acc <= 40'sh8000000000;
      end else begin
        acc <= acc_sum[39:0];
      end
    end
    case (state)
      qconv_pkg::S_BASE1: begin
        acc   <= '0;
        ic    <= '0;
        k     <= '0;
        xbase <= '0;
      end
      qconv_pkg::S_BASE3: begin
        widx <= prod[qconv_pkg::WGT_AW-1:0];
      end
      qconv_pkg::S_MAC: begin
        widx <= widx + qconv_pkg::WGT_AW'(1);
        if (k == n_taps - 4'd1) begin
          k     <= '0;
          ic    <= ic + 5'd1;
          xbase <= xbase + qconv_pkg::ACT_AW'(in_len);
        end else begin
          k <= k + 4'd1;
        end
      end
      qconv_pkg::S_FIN2: begin
        b16 <= b_round[31:4];
      end
      qconv_pkg::S_FIN3: begin
        lo_sum <= 64'($signed(prod[40:0])) + (64'(b16) <<< 16);
      end
      qconv_pkg::S_FIN4: begin
        sum <= (64'($signed(prod[41:0])) <<< 19) + lo_sum;
      end
      qconv_pkg::S_FIN5: begin
        if (out_load) begin
          out_value        <= r_sat;
          out_channel_echo <= oc;
          position_echo    <= pos;
        end
      end
      default: ;
    endcase
  end

  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    (in_accept && mode == qconv_pkg::MODE_COMPUTE) |=> state == qconv_pkg::S_BASE1)
    else $error("compute word did not start the sequencer");

  a_mac_in_loop: assert property (@(posedge clk) disable iff (rst)
    p2_v |-> (state == qconv_pkg::S_MAC || state == qconv_pkg::S_DRAIN1 ||
              state == qconv_pkg::S_DRAIN2))
    else $error("product pending outside the accumulate loop");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == qconv_pkg::S_FIN5))
    else $error("result word raised outside the final step");

endmodule

/* hw/rtl/qconv_ram.sv */
// ----------------------------------------------------------------------------
// qconv_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qconv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
